// File: rtl/core/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// lfuc_pkg
// Widths, codes and entry layout shared by the LFU cache and its channels.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  // payload widths
  localparam int KEY_W = 31;
  localparam int VAL_W = 31;
  localparam int CNT_W = 16;
  localparam int CAP_W = 5;

  // default number of entries
  localparam int DEF_ENTRIES = 16;

  // capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(16);

  // use count saturates here
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // one word of the entry memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } ent_t;

endpackage

// File: rtl/core/lfuc_if.sv
// ----------------------------------------------------------------------------
// lfuc_if
// Request and response channels of the LFU cache, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfuc_req_if;
  import lfuc_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] data_in;

  modport source (output valid, action, key, data_in, input ready);
  modport sink   (input valid, action, key, data_in, output ready);
endinterface

interface lfuc_rsp_if;
  import lfuc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// File: rtl/core/lfu_cache_lru_tiebreak_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie break. Entries live in two synchronous memories.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_i     in    valid/ready    action, key, data_in
//  rsp_o     out   valid/ready    hit, read_value, evicted, evicted_key
//  cfg       in    cfg_we_i       cfg_wdata_i (capacity_in_use)
//
//  An item is accepted in the idle state, then makes one pass over the
//  entry memory for lookup and victim search, passes a decision state,
//  makes one read-modify-write pass over the recency memory and ends in
//  the hand-off state. A get miss skips the recency pass. Each memory
//  has a single read port.
//  One item is in work at a time; a new item is taken while a result waits.
//  Reset clears valid bits, occupancy and control; memories need no clearing.
//  A stalled response holds the next result in the hand-off state.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_unit #(
  parameter int ENTRIES = lfuc_pkg::DEF_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lfuc_pkg::CAP_W-1:0] cfg_wdata_i,
  lfuc_req_if.sink                   req_i,
  lfuc_rsp_if.source                 rsp_o
);
  import lfuc_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration and occupancy
  logic [CAP_W-1:0] cap_q;
  logic [OW-1:0]    occ_q, occ_d;
  logic [ENTRIES-1:0] valid_q, valid_d;

  // latched item
  logic             act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] data_q;

  // memory sweep counter and read pipeline
  logic          issue_q, issue_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic          last_rd;

  // memories
  ent_t          ent_mem [ENTRIES];
  logic [IW-1:0] rank_mem [ENTRIES];
  ent_t          ent_rdata_q;
  logic [IW-1:0] rank_rdata_q;
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  ent_t          ent_wdata;
  logic          rank_we;
  logic [IW-1:0] rank_wdata;

  // scan trackers
  logic             m_fnd_q, m_fnd_d;
  logic [IW-1:0]    m_idx_q, m_idx_d;
  logic [IW-1:0]    m_rank_q, m_rank_d;
  logic [VAL_W-1:0] m_val_q, m_val_d;
  logic [CNT_W-1:0] m_cnt_q, m_cnt_d;
  logic             v_fnd_q, v_fnd_d;
  logic [IW-1:0]    v_idx_q, v_idx_d;
  logic [IW-1:0]    v_rank_q, v_rank_d;
  logic [KEY_W-1:0] v_key_q, v_key_d;
  logic [CNT_W-1:0] v_cnt_q, v_cnt_d;
  logic             f_fnd_q, f_fnd_d;
  logic [IW-1:0]    f_idx_q, f_idx_d;

  // recency update controls
  logic [IW-1:0] tgt_q, tgt_d;
  logic [IW-1:0] thr_q, thr_d;
  logic          age_all_q, age_all_d;

  // pending result and output register
  logic             r_hit_q, r_hit_d;
  logic [VAL_W-1:0] r_val_q, r_val_d;
  logic             r_ev_q, r_ev_d;
  logic [KEY_W-1:0] r_evk_q, r_evk_d;
  logic             o_vld_q, o_vld_d;
  logic             o_hit_q;
  logic [VAL_W-1:0] o_val_q;
  logic             o_ev_q;
  logic [KEY_W-1:0] o_evk_q;
  logic             o_load;

  // effective capacity
  logic [CMPW-1:0] cap_ext, eff_cap;
  logic            need_evict;

  logic req_acc;
  logic ent_v;
  logic cnt_max;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign last_rd     = rd_vld_q && (rd_idx_q == LAST_IDX);
  assign ent_v       = valid_q[rd_idx_q];
  assign cnt_max     = (m_cnt_q == CNT_MAX);

  // capacity clamp: zero acts as one, above entries acts as entries
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = (CMPW'(occ_q) >= eff_cap);
  end

  // entry memories, registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rd_idx_q] <= rank_wdata;
    end
    rank_rdata_q <= rank_mem[idx_q];
  end

  // recency write-back during the update pass
  always_comb begin
    rank_we    = (state_q == ST_UPDATE) && rd_vld_q;
    rank_wdata = rank_rdata_q;
    if (rd_idx_q == tgt_q) begin
      rank_wdata = '0;
    end else if (ent_v && (age_all_q || (rank_rdata_q < thr_q))) begin
      rank_wdata = rank_rdata_q + IW'(1);
    end
  end

  // sequencer, scan trackers and decision
  always_comb begin
    state_d   = state_q;
    issue_d   = issue_q;
    idx_d     = idx_q;
    occ_d     = occ_q;
    valid_d   = valid_q;
    m_fnd_d   = m_fnd_q;
    m_idx_d   = m_idx_q;
    m_rank_d  = m_rank_q;
    m_val_d   = m_val_q;
    m_cnt_d   = m_cnt_q;
    v_fnd_d   = v_fnd_q;
    v_idx_d   = v_idx_q;
    v_rank_d  = v_rank_q;
    v_key_d   = v_key_q;
    v_cnt_d   = v_cnt_q;
    f_fnd_d   = f_fnd_q;
    f_idx_d   = f_idx_q;
    tgt_d     = tgt_q;
    thr_d     = thr_q;
    age_all_d = age_all_q;
    r_hit_d   = r_hit_q;
    r_val_d   = r_val_q;
    r_ev_d    = r_ev_q;
    r_evk_d   = r_evk_q;
    ent_we    = 1'b0;
    ent_waddr = m_idx_q;
    ent_wdata = '{key: key_q, value: data_q, count: CNT_W'(1)};
    o_load    = 1'b0;

    // sweep address advance
    if (issue_q) begin
      if (idx_q == LAST_IDX) begin
        issue_d = 1'b0;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_SCAN;
          issue_d = 1'b1;
          idx_d   = '0;
          m_fnd_d = 1'b0;
          v_fnd_d = 1'b0;
          f_fnd_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q) begin
          // first matching valid entry
          if (ent_v && !m_fnd_q && (ent_rdata_q.key == key_q)) begin
            m_fnd_d  = 1'b1;
            m_idx_d  = rd_idx_q;
            m_rank_d = rank_rdata_q;
            m_val_d  = ent_rdata_q.value;
            m_cnt_d  = ent_rdata_q.count;
          end
          // first free slot
          if (!ent_v && !f_fnd_q) begin
            f_fnd_d = 1'b1;
            f_idx_d = rd_idx_q;
          end
          // lowest count, oldest among equals
          if (ent_v && (!v_fnd_q || (ent_rdata_q.count < v_cnt_q) ||
              ((ent_rdata_q.count == v_cnt_q) && (rank_rdata_q > v_rank_q)))) begin
            v_fnd_d  = 1'b1;
            v_idx_d  = rd_idx_q;
            v_rank_d = rank_rdata_q;
            v_key_d  = ent_rdata_q.key;
            v_cnt_d  = ent_rdata_q.count;
          end
        end
        if (last_rd) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        r_hit_d   = m_fnd_q;
        r_val_d   = '0;
        r_ev_d    = 1'b0;
        r_evk_d   = '0;
        age_all_d = 1'b0;
        state_d   = ST_DONE;
        if (m_fnd_q) begin
          // hit: bump count, refresh recency, put overwrites value
          ent_we          = 1'b1;
          ent_waddr       = m_idx_q;
          ent_wdata.count = cnt_max ? m_cnt_q : m_cnt_q + CNT_W'(1);
          tgt_d           = m_idx_q;
          thr_d           = m_rank_q;
          if (act_q == ACT_PUT) begin
            ent_wdata.value = data_q;
          end else begin
            ent_wdata.value = m_val_q;
            r_val_d         = m_val_q;
          end
          state_d = ST_UPDATE;
          issue_d = 1'b1;
          idx_d   = '0;
        end else if (act_q == ACT_PUT) begin
          ent_we = 1'b1;
          if (need_evict) begin
            // replace the victim in place
            ent_waddr = v_idx_q;
            tgt_d     = v_idx_q;
            thr_d     = v_rank_q;
            r_ev_d    = 1'b1;
            r_evk_d   = v_key_q;
          end else begin
            // fill a free slot, every valid entry ages
            ent_waddr          = f_idx_q;
            tgt_d              = f_idx_q;
            age_all_d          = 1'b1;
            valid_d[f_idx_q]   = 1'b1;
            occ_d              = occ_q + OW'(1);
          end
          state_d = ST_UPDATE;
          issue_d = 1'b1;
          idx_d   = '0;
        end
      end
      ST_UPDATE: begin
        if (last_rd) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!o_vld_q || rsp_o.ready) begin
          o_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    o_vld_d = o_vld_q;
    if (o_load) begin
      o_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      o_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cap_q    <= CAP_RST;
      occ_q    <= '0;
      valid_q  <= '0;
      issue_q  <= 1'b0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      m_fnd_q  <= 1'b0;
      v_fnd_q  <= 1'b0;
      f_fnd_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      valid_q  <= valid_d;
      issue_q  <= issue_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue_q;
      rd_idx_q <= idx_q;
      m_fnd_q  <= m_fnd_d;
      v_fnd_q  <= v_fnd_d;
      f_fnd_q  <= f_fnd_d;
      o_vld_q  <= o_vld_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      act_q  <= req_i.action;
      key_q  <= req_i.key;
      data_q <= req_i.data_in;
    end
    m_idx_q   <= m_idx_d;
    m_rank_q  <= m_rank_d;
    m_val_q   <= m_val_d;
    m_cnt_q   <= m_cnt_d;
    v_idx_q   <= v_idx_d;
    v_rank_q  <= v_rank_d;
    v_key_q   <= v_key_d;
    v_cnt_q   <= v_cnt_d;
    f_idx_q   <= f_idx_d;
    tgt_q     <= tgt_d;
    thr_q     <= thr_d;
    age_all_q <= age_all_d;
    r_hit_q   <= r_hit_d;
    r_val_q   <= r_val_d;
    r_ev_q    <= r_ev_d;
    r_evk_q   <= r_evk_d;
    if (o_load) begin
      o_hit_q <= r_hit_q;
      o_val_q <= r_val_q;
      o_ev_q  <= r_ev_q;
      o_evk_q <= r_evk_q;
    end
  end

  assign rsp_o.valid       = o_vld_q;
  assign rsp_o.hit         = o_hit_q;
  assign rsp_o.read_value  = o_val_q;
  assign rsp_o.evicted     = o_ev_q;
  assign rsp_o.evicted_key = o_evk_q;

endmodule

// File: rtl/core/lfuc_checker.sv
// ----------------------------------------------------------------------------
// lfuc_checker
// Port-level checks of the LFU cache, bound to the cache unit.
// ----------------------------------------------------------------------------
module lfuc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_hit_i,
  input logic [lfuc_pkg::VAL_W-1:0] rsp_read_value_i,
  input logic                       rsp_evicted_i,
  input logic [lfuc_pkg::KEY_W-1:0] rsp_evicted_key_i
);
  import lfuc_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_read_value_i)
      && $stable(rsp_evicted_key_i)))
    else $error("response changed while stalled");

  // only one item in work: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("item accepted while another is in work");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_evicted_i))
    else $error("hit with eviction");

  // read value only on a hit
  a_value_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |-> (rsp_read_value_i == '0))
    else $error("read value without hit");

  // evicted key only on eviction
  a_key_on_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_evicted_i) |-> (rsp_evicted_key_i == '0))
    else $error("evicted key without eviction");

endmodule

bind lfu_cache_lru_tiebreak_unit lfuc_checker u_lfuc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_evicted_i     (rsp_o.evicted),
  .rsp_evicted_key_i (rsp_o.evicted_key)
);
